// ===== rtl/mwf_pkg.sv =====
// Shared constants, types and register codes of the clipped window median filter.
`default_nettype none
package mwf_pkg;
  localparam int MAX_KERNEL  = 7;
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_RAD     = (MAX_KERNEL - 1) / 2;
  localparam int RAD_W       = $clog2(MAX_RAD + 1);
  localparam int KW          = $clog2(MAX_KERNEL + 1);
  localparam int STORE_DEPTH = MAX_KERNEL * MAX_WIDTH;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int WIN_MAX     = MAX_KERNEL * MAX_KERNEL;
  localparam int CNT_W       = $clog2(WIN_MAX + 1);
  localparam int LIN_W       = 26;
  localparam int PIX_W       = 24;
  localparam int QDEPTH      = 4;
  localparam int QW          = $clog2(QDEPTH);

  localparam logic OP_PIXEL = 1'b0;

  typedef enum logic [1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_KERNEL,
    REG_COLOR
  } reg_idx_t;

  typedef struct packed {
    logic [10:0]      w;
    logic [15:0]      h;
    logic [RAD_W-1:0] r;
    logic             color;
  } cfg_t;

  typedef struct packed {
    logic [15:0]   row;
    logic [9:0]    col;
    logic [AW-1:0] addr;
    logic          last;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SETUP,
    B_ADDR,
    B_SCAN,
    B_FLUSH,
    B_DECIDE,
    B_DONE
  } bstate_t;
endpackage
`default_nettype wire

// ===== rtl/clipped_window_median_filter.sv =====
// Top level of the clipped window median filter.
//
// The block takes raster-order pixels on the in_ stream and returns, in the
// same order, each pixel's per-channel median over a square window of radius
// kernel_size/2 that is clipped at the image borders; with an even number of
// samples the upper median is taken. The front part writes each pixel into a
// 7168-entry line store and, once enough rows are in, puts one job per output
// pixel into a four-entry queue; it takes one item per cycle while the queue
// has room and no finished frame is draining. The back part works a job out
// by scanning the window from the line store eight times, deciding one bit of
// all three medians per scan and reading one sample at a time through the
// single read port of the line store. Send drain items (in_tuser high) after
// the last pixel to flush the remaining outputs; out_tlast marks the frame's
// final pixel. The next frame's pixels are held off until the back has
// finished the previous frame. Any configuration write restarts the frame and
// must be made while idle.
`default_nettype none
module clipped_window_median_filter import mwf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // chan0_in, chan1_in, chan2_in
  input  wire logic        in_tuser,   // opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // chan0_out, chan1_out, chan2_out
  output logic             out_tlast,  // frame_last
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  logic [10:0] width_r;
  logic [15:0] height_r;
  logic [2:0]  kernel_r;
  logic        color_r;
  cfg_t        cfg;
  logic        restart;
  logic        wr_en, push, q_valid, q_full, q_pop, back_idle;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [PIX_W-1:0] wr_data, rd_data;
  job_t        push_job, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd1024;
      height_r <= 16'd768;
      kernel_r <= 3'd3;
      color_r  <= 1'b1;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_WIDTH:  width_r  <= cfg_data[10:0];
        REG_HEIGHT: height_r <= cfg_data;
        REG_KERNEL: kernel_r <= cfg_data[2:0];
        REG_COLOR:  color_r  <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  assign restart = cfg_wr_en;

  // Out-of-range settings are folded into their nearest usable values.
  always_comb begin
    cfg.w     = (width_r == 11'd0) ? 11'd1 :
                (width_r > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_r;
    cfg.h     = (height_r == 16'd0) ? 16'd1 : height_r;
    cfg.r     = (32'(kernel_r >> 1) > 32'(MAX_RAD)) ? RAD_W'(MAX_RAD)
                                                    : RAD_W'(kernel_r >> 1);
    cfg.color = color_r;
  end

  mwf_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .restart(restart),
    .in_valid(in_tvalid), .in_ready(in_tready), .opcode(in_tuser), .pix(in_tdata),
    .q_full(q_full), .drained(!q_valid && back_idle),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .push(push), .push_job(push_job)
  );

  mwf_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_job(push_job), .pop(q_pop),
    .head(q_head), .not_empty(q_valid), .full(q_full)
  );

  mwf_ram #(.W(PIX_W), .D(STORE_DEPTH)) u_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  mwf_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .q_valid(q_valid), .q_head(q_head),
    .q_pop(q_pop), .idle(back_idle), .rd_addr(rd_addr), .rd_data(rd_data),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(out_tdata),
    .out_last(out_tlast)
  );
endmodule
`default_nettype wire

// ===== rtl/mwf_ram.sv =====
// Generic single write, single read RAM with registered read data.
`default_nettype none
module mwf_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [$clog2(D)-1:0] wr_addr,
  input  wire logic [W-1:0]         wr_data,
  input  wire logic [$clog2(D)-1:0] rd_addr,
  output logic      [W-1:0]         rd_data
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ===== rtl/mwf_queue.sv =====
// Short job queue between the front and the back.
`default_nettype none
module mwf_queue import mwf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head,
  output logic      not_empty,
  output logic      full
);
  job_t            slot_r [QDEPTH];
  logic [QW-1:0]   wp_r, rp_r;
  logic [QW:0]     cnt_r;

  assign head      = slot_r[rp_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == (QW+1)'(QDEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        slot_r[wp_r] <= push_job;
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (QW+1)'(push) - (QW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/mwf_front.sv =====
// Front part: accepts items, writes the line store and issues output jobs.
`default_nettype none
module mwf_front import mwf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire logic             restart,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             opcode,
  input  wire logic [PIX_W-1:0] pix,
  input  wire logic             q_full,
  input  wire logic             drained,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output logic [PIX_W-1:0]      wr_data,
  output logic                  push,
  output job_t                  push_job
);
  logic [15:0]      in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [9:0]       in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [LIN_W-1:0] in_lin_r, in_lin_nxt, out_lin_r, out_lin_nxt;
  logic [AW-1:0]    wa_r, wa_nxt, oa_r, oa_nxt;
  logic             hold_r, hold_nxt;
  logic             acc, complete, is_pix, complete_new, due;
  logic [10:0]      in_col_inc, out_col_inc;
  logic [LIN_W:0]   lag, due_lim;

  assign in_ready = !q_full && !(hold_r && !drained);
  assign acc      = in_valid && in_ready;
  assign complete = (in_row_r >= cfg.h);
  assign is_pix   = acc && (opcode == OP_PIXEL) && !complete;
  assign lag      = (LIN_W+1)'(cfg.r) * (LIN_W+1)'(cfg.w) + (LIN_W+1)'(cfg.r);
  assign due_lim  = {1'b0, out_lin_r} + lag;
  assign in_col_inc  = {1'b0, in_col_r} + 11'd1;
  assign out_col_inc = {1'b0, out_col_r} + 11'd1;

  assign wr_en   = is_pix;
  assign wr_addr = wa_r;
  assign wr_data = cfg.color ? pix : {16'd0, pix[7:0]};

  always_comb begin
    in_row_nxt = in_row_r;
    in_col_nxt = in_col_r;
    in_lin_nxt = in_lin_r;
    wa_nxt     = wa_r;
    if (is_pix) begin
      in_lin_nxt = in_lin_r + 1'b1;
      wa_nxt     = (wa_r == AW'(STORE_DEPTH - 1)) ? '0 : wa_r + 1'b1;
      if (in_col_inc >= cfg.w) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_col_nxt = in_col_inc[9:0];
      end
    end
    complete_new = (in_row_nxt >= cfg.h);
    due = is_pix ? (complete_new || ({1'b0, in_lin_r} >= due_lim)) : (acc && complete);

    push     = due;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    if (out_col_inc >= cfg.w) begin
      out_col_nxt = '0;
      out_row_nxt = out_row_r + 1'b1;
    end else begin
      out_col_nxt = out_col_inc[9:0];
    end
    push_job.row  = out_row_r;
    push_job.col  = out_col_r;
    push_job.addr = oa_r;
    push_job.last = (out_row_nxt >= cfg.h);

    out_lin_nxt = out_lin_r;
    oa_nxt      = oa_r;
    hold_nxt    = hold_r && !drained;
    if (!due) begin
      out_row_nxt = out_row_r;
      out_col_nxt = out_col_r;
    end else begin
      out_lin_nxt = out_lin_r + 1'b1;
      oa_nxt      = (oa_r == AW'(STORE_DEPTH - 1)) ? '0 : oa_r + 1'b1;
    end
    // The frame's last job or restart resets the counters; after that job
    // new pixels wait until the back has read everything of the old frame.
    if ((due && push_job.last) || restart) begin
      in_row_nxt  = '0;
      in_col_nxt  = '0;
      in_lin_nxt  = '0;
      wa_nxt      = '0;
      out_row_nxt = '0;
      out_col_nxt = '0;
      out_lin_nxt = '0;
      oa_nxt      = '0;
      hold_nxt    = !restart;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r  <= '0;
      in_col_r  <= '0;
      in_lin_r  <= '0;
      wa_r      <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      out_lin_r <= '0;
      oa_r      <= '0;
      hold_r    <= 1'b0;
    end else begin
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      in_lin_r  <= in_lin_nxt;
      wa_r      <= wa_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
      out_lin_r <= out_lin_nxt;
      oa_r      <= oa_nxt;
      hold_r    <= hold_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/mwf_back.sv =====
// Back part: gathers one clipped window per job and finds each channel's median
// by a bit-by-bit rank search over repeated window scans.
`default_nettype none
module mwf_back import mwf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire logic             q_valid,
  input  wire job_t             q_head,
  output logic                  q_pop,
  output logic                  idle,
  output logic [AW-1:0]         rd_addr,
  input  wire logic [PIX_W-1:0] rd_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [PIX_W-1:0]      out_data,
  output logic                  out_last
);
  bstate_t          st_r, st_nxt;
  job_t             job_r, job_nxt;
  logic [KW-1:0]    nx_r, nx_nxt, ny_r, ny_nxt, ix_r, ix_nxt, iy_r, iy_nxt;
  logic [AW-1:0]    off_r, off_nxt, start_r, start_nxt, ra_r, ra_nxt;
  logic [10:0]      step_r, step_nxt;
  logic             vld_r, vld_nxt, first_r, first_nxt;
  logic [2:0]       bit_r, bit_nxt;
  logic [7:0]       pre_r [3], pre_nxt [3];
  logic [CNT_W-1:0] cnt_r [3], cnt_nxt [3], k_r [3], k_nxt [3], n_r, n_nxt;
  logic             ov_r, ov_nxt, ol_r, ol_nxt;
  logic [PIX_W-1:0] od_r, od_nxt;

  logic [RAD_W-1:0] dy, dx, dyd, dxd;
  logic [16:0]      ysum;
  logic [10:0]      xsum;
  logic [AW:0]      inc_sum;
  logic [10:0]      inc;
  logic [7:0]       mask, dch;
  logic [CNT_W-1:0] keff;
  logic             slot_free;

  assign idle      = (st_r == B_IDLE);
  assign rd_addr   = ra_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign out_last  = ol_r;
  assign slot_free = !ov_r || out_ready;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_IDLE:   if (q_valid) st_nxt = B_SETUP;
      B_SETUP:  st_nxt = B_ADDR;
      B_ADDR:   st_nxt = B_SCAN;
      B_SCAN:   if (ix_r == nx_r - 1'b1 && iy_r == ny_r - 1'b1) st_nxt = B_FLUSH;
      B_FLUSH:  st_nxt = B_DECIDE;
      B_DECIDE: st_nxt = (bit_r == 3'd0) ? B_DONE : B_SCAN;
      B_DONE:   if (slot_free) st_nxt = B_IDLE;
      default:  st_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (st_r == B_IDLE) && q_valid;
    job_nxt   = q_pop ? q_head : job_r;
    nx_nxt    = nx_r;
    ny_nxt    = ny_r;
    off_nxt   = off_r;
    step_nxt  = step_r;
    start_nxt = start_r;
    ra_nxt    = ra_r;
    ix_nxt    = ix_r;
    iy_nxt    = iy_r;
    vld_nxt   = 1'b0;
    first_nxt = first_r;
    bit_nxt   = bit_r;
    n_nxt     = n_r;
    ov_nxt    = ov_r && !out_ready;
    ol_nxt    = ol_r;
    od_nxt    = od_r;
    pre_nxt   = pre_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    dch       = '0;
    keff      = '0;

    // Window bounds, clipped to the image.
    dy   = (job_r.row > 16'(cfg.r)) ? cfg.r : RAD_W'(job_r.row);
    dx   = (job_r.col > 10'(cfg.r)) ? cfg.r : RAD_W'(job_r.col);
    ysum = {1'b0, job_r.row} + 17'(cfg.r);
    xsum = {1'b0, job_r.col} + 11'(cfg.r);
    dyd  = (ysum < {1'b0, cfg.h}) ? cfg.r : RAD_W'(cfg.h - 16'd1 - job_r.row);
    dxd  = (xsum < cfg.w) ? cfg.r : RAD_W'(cfg.w - 11'd1 - {1'b0, job_r.col});

    inc     = (ix_r == nx_r - 1'b1) ? step_r : 11'd1;
    inc_sum = {1'b0, ra_r} + (AW+1)'(inc);
    mask    = 8'(8'hFE << bit_r);

    // Count, per channel, the window samples that match the prefix found so
    // far and have a zero in the bit under test.
    if (vld_r) begin
      n_nxt = n_r + 1'b1;
      for (int c = 0; c < 3; c++) begin
        dch = rd_data[8*c +: 8];
        if ((((dch ^ pre_r[c]) & mask) == 8'd0) && !dch[bit_r]) begin
          cnt_nxt[c] = cnt_r[c] + 1'b1;
        end
      end
    end

    case (st_r)
      B_SETUP: begin
        ny_nxt   = KW'(dy) + KW'(dyd) + 1'b1;
        nx_nxt   = KW'(dx) + KW'(dxd) + 1'b1;
        off_nxt  = AW'(dy) * AW'(cfg.w) + AW'(dx);
        step_nxt = cfg.w - 11'(dx) - 11'(dxd);
      end
      B_ADDR: begin
        start_nxt = (job_r.addr >= off_r) ? job_r.addr - off_r
                                          : AW'((AW+1)'(job_r.addr) +
                                                (AW+1)'(STORE_DEPTH) - (AW+1)'(off_r));
        ra_nxt    = start_nxt;
        ix_nxt    = '0;
        iy_nxt    = '0;
        first_nxt = 1'b1;
        bit_nxt   = 3'd7;
        n_nxt     = '0;
        for (int c = 0; c < 3; c++) begin
          pre_nxt[c] = '0;
          cnt_nxt[c] = '0;
        end
      end
      B_SCAN: begin
        vld_nxt = 1'b1;
        ra_nxt  = (inc_sum >= (AW+1)'(STORE_DEPTH)) ? AW'(inc_sum - (AW+1)'(STORE_DEPTH))
                                                   : AW'(inc_sum);
        if (ix_r == nx_r - 1'b1) begin
          ix_nxt = '0;
          iy_nxt = iy_r + 1'b1;
        end else begin
          ix_nxt = ix_r + 1'b1;
        end
      end
      B_DECIDE: begin
        for (int c = 0; c < 3; c++) begin
          keff = first_r ? (n_r >> 1) : k_r[c];
          if (keff < cnt_r[c]) begin
            k_nxt[c] = keff;
          end else begin
            k_nxt[c] = keff - cnt_r[c];
            pre_nxt[c][bit_r] = 1'b1;
          end
          cnt_nxt[c] = '0;
        end
        first_nxt = 1'b0;
        bit_nxt   = bit_r - 1'b1;
        ra_nxt    = start_r;
        ix_nxt    = '0;
        iy_nxt    = '0;
      end
      B_DONE: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          ol_nxt = job_r.last;
          od_nxt = cfg.color ? {pre_r[2], pre_r[1], pre_r[0]} : {16'd0, pre_r[0]};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= B_IDLE;
      vld_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      vld_r <= vld_nxt;
      ov_r  <= ov_nxt;
    end
    job_r   <= job_nxt;
    nx_r    <= nx_nxt;
    ny_r    <= ny_nxt;
    off_r   <= off_nxt;
    step_r  <= step_nxt;
    start_r <= start_nxt;
    ra_r    <= ra_nxt;
    ix_r    <= ix_nxt;
    iy_r    <= iy_nxt;
    first_r <= first_nxt;
    bit_r   <= bit_nxt;
    n_r     <= n_nxt;
    ol_r    <= ol_nxt;
    od_r    <= od_nxt;
    pre_r   <= pre_nxt;
    cnt_r   <= cnt_nxt;
    k_r     <= k_nxt;
  end
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the clipped window median filter.
`default_nettype none
module tb_top import mwf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // The input side carries pixels or drain ticks, selected by the user bit.
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] c2;
    logic [7:0] c1;
    logic [7:0] c0;
  } pix_item_t;

  typedef struct packed {
    logic [7:0] m2;
    logic [7:0] m1;
    logic [7:0] m0;
    logic       last;
  } median_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  clipped_window_median_filter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow copy of the filter state, kept in step with the accepted items.
  logic [10:0] sh_width;
  logic [15:0] sh_height;
  logic [2:0]  sh_kernel;
  logic        sh_color;
  logic [23:0] sh_store [STORE_DEPTH];
  int unsigned sh_in_row, sh_in_col, sh_out_row, sh_out_col;

  pix_item_t   pending_pix[$];
  median_t     expected_medians[$];
  int          mismatches;
  int          medians_seen;
  int          frames_seen;
  int          items_sent;

  // Register write: the block restarts its frame, and so does the shadow.
  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_WIDTH:  sh_width  = val[10:0];
      REG_HEIGHT: sh_height = val;
      REG_KERNEL: sh_kernel = val[2:0];
      REG_COLOR:  sh_color  = val[0];
      default: ;
    endcase
    sh_in_row = 0; sh_in_col = 0; sh_out_row = 0; sh_out_col = 0;
  endtask

  function automatic logic [7:0] upper_median(input logic [7:0] v[$]);
    v.sort();
    return v[v.size() / 2];
  endfunction

  // Works out the result, if any, that one accepted item causes.
  task automatic predict_median(input pix_item_t it);
    int unsigned w, h, r, lag, p, q, y0, y1, x0, x1;
    bit          complete, ready;
    logic [7:0]  v0[$], v1[$], v2[$];
    logic [23:0] s;
    median_t     m;
    w = (sh_width == 0) ? 1 : (sh_width > MAX_WIDTH ? MAX_WIDTH : sh_width);
    h = (sh_height == 0) ? 1 : sh_height;
    r = sh_kernel / 2;
    if (r > MAX_RAD) r = MAX_RAD;
    lag = r * w + r;
    complete = sh_in_row >= h;
    if (sh_out_row >= h) begin
      sh_in_row = 0; sh_in_col = 0; sh_out_row = 0; sh_out_col = 0;
      complete = 0;
    end
    p = sh_out_row * w + sh_out_col;
    if (it.op == OP_PIXEL && !complete) begin
      q = sh_in_row * w + sh_in_col;
      sh_store[q % STORE_DEPTH] = sh_color ? {it.c2, it.c1, it.c0} : {16'h0, it.c0};
      sh_in_col++;
      if (sh_in_col >= w) begin
        sh_in_col = 0;
        sh_in_row++;
      end
      complete = sh_in_row >= h;
      ready = complete || q >= p + lag;
    end else begin
      ready = complete;
    end
    if (!ready) return;
    y0 = sh_out_row > r ? sh_out_row - r : 0;
    y1 = sh_out_row + r < h ? sh_out_row + r : h - 1;
    x0 = sh_out_col > r ? sh_out_col - r : 0;
    x1 = sh_out_col + r < w ? sh_out_col + r : w - 1;
    for (int unsigned y = y0; y <= y1; y++) begin
      for (int unsigned x = x0; x <= x1; x++) begin
        s = sh_store[(y * w + x) % STORE_DEPTH];
        v0.insert(v0.size(), s[7:0]);
        v1.insert(v1.size(), s[15:8]);
        v2.insert(v2.size(), s[23:16]);
      end
    end
    m.m0 = upper_median(v0);
    m.m1 = sh_color ? upper_median(v1) : 8'h0;
    m.m2 = sh_color ? upper_median(v2) : 8'h0;
    m.last = 1'b0;
    sh_out_col++;
    if (sh_out_col >= w) begin
      sh_out_col = 0;
      sh_out_row++;
    end
    if (sh_out_row >= h) begin
      m.last = 1'b1;
      sh_in_row = 0; sh_in_col = 0; sh_out_row = 0; sh_out_col = 0;
    end
    expected_medians.insert(expected_medians.size(), m);
  endtask

  // Driver: bursts of random length separated by random gaps. The prediction
  // is made at the edge where the item is taken, so order always matches.
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_median(pending_pix.pop_front());
        if (burst_left > 0) burst_left--;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_pix.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {pending_pix[0].c2, pending_pix[0].c1, pending_pix[0].c0};
          in_tuser  <= pending_pix[0].op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: long ready stretches alternate with stall runs.
  int stall_phase;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_phase = 0;
    end else begin
      stall_phase = (stall_phase + 1) % 64;
      if (stall_phase < 24) out_tready <= 1'b1;
      else if (stall_phase < 40) out_tready <= ($urandom_range(0, 2) != 0);
      else out_tready <= ($urandom_range(0, 4) == 0);
    end
  end

  // Monitor: compares each median with the oldest expectation.
  always @(posedge clk) begin
    median_t exp_m;
    if (rst_n && out_tvalid && out_tready) begin
      medians_seen++;
      if (out_tlast) frames_seen++;
      if (expected_medians.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected median %h last %b", out_tdata, out_tlast);
      end else begin
        exp_m = expected_medians.pop_front();
        if (out_tdata !== {exp_m.m2, exp_m.m1, exp_m.m0} || out_tlast !== exp_m.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: median got %h/%b expected %h/%b", out_tdata, out_tlast,
                     {exp_m.m2, exp_m.m1, exp_m.m0}, exp_m.last);
        end
      end
    end
  end

  task automatic add_pixel(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
    pix_item_t it;
    it.op = OP_PIXEL; it.c0 = a; it.c1 = b; it.c2 = c;
    pending_pix.insert(pending_pix.size(), it);
    items_sent++;
  endtask

  task automatic add_drain(input int n, input bit junk);
    pix_item_t it;
    repeat (n) begin
      it.op = OP_DRAIN;
      it.c0 = junk ? 8'($urandom) : 8'h0;
      it.c1 = junk ? 8'($urandom) : 8'h0;
      it.c2 = junk ? 8'($urandom) : 8'h0;
      pending_pix.insert(pending_pix.size(), it);
      items_sent++;
    end
  endtask

  // Queues one whole frame of random pixels followed by enough drain ticks.
  // Values are sometimes pushed to the extremes so that every bit toggles.
  task automatic add_frame(input int w, input int h, input int r);
    int mode, lag, need;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < w * h; i++) begin
      case (mode)
        0: add_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        1: add_pixel($urandom_range(0, 1) ? 8'hFF : 8'h00, 8'($urandom_range(250, 255)),
                     8'($urandom_range(0, 5)));
        default: add_pixel(8'($urandom_range(100, 140)), 8'($urandom),
                           8'($urandom_range(0, 255)));
      endcase
    end
    // Outputs still pending after the last pixel: the lag, at most all but one.
    lag  = r * w + r;
    need = (lag < w * h - 1) ? lag : w * h - 1;
    add_drain(need + int'($urandom_range(0, 2)), 0);
  endtask

  // Waits for the queued items to be taken and every median to come back,
  // then lets the back end settle before the next register write.
  task automatic wait_idle();
    while (pending_pix.size() > 0 || in_tvalid || expected_medians.size() > 0)
      @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  task automatic run_setting(input int w, input int h, input int k, input bit col,
                             input int frames);
    int r, ew, eh;
    write_reg(REG_WIDTH, 16'(w));
    write_reg(REG_HEIGHT, 16'(h));
    write_reg(REG_KERNEL, 16'(k));
    write_reg(REG_COLOR, 16'(col));
    r  = k / 2;
    ew = (w < 1) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
    eh = (h < 1) ? 1 : h;
    repeat (frames) add_frame(ew, eh, r);
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    mismatches = 0;
    medians_seen = 0;
    frames_seen = 0;
    items_sent = 0;
    sh_width = 11'd1024; sh_height = 16'd768; sh_kernel = 3'd3; sh_color = 1'b1;
    foreach (sh_store[i]) sh_store[i] = '0;
    sh_in_row = 0; sh_in_col = 0; sh_out_row = 0; sh_out_col = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: a 3x3 frame with extreme values, a drain tick before the
    // frame is complete, and pixels after the last one acting as drain ticks.
    write_reg(REG_WIDTH, 16'd3);
    write_reg(REG_HEIGHT, 16'd3);
    write_reg(REG_KERNEL, 16'd3);
    write_reg(REG_COLOR, 16'd1);
    add_pixel(8'h00, 8'hFF, 8'h00);
    add_drain(1, 1);
    add_pixel(8'hFF, 8'h00, 8'hFF);
    add_pixel(8'h80, 8'h7F, 8'h01);
    add_pixel(8'h01, 8'hFE, 8'h80);
    add_pixel(8'hFF, 8'hFF, 8'hFF);
    add_pixel(8'h00, 8'h00, 8'h00);
    add_pixel(8'h55, 8'hAA, 8'h55);
    add_pixel(8'hAA, 8'h55, 8'hAA);
    add_pixel(8'h7F, 8'h80, 8'hFE);
    add_pixel(8'h12, 8'h34, 8'h56);
    add_pixel(8'h9A, 8'hBC, 8'hDE);
    add_drain(3, 1);
    wait_idle();

    // Out of range settings: width zero, height zero, kernel zero, gray mode.
    run_setting(0, 0, 0, 0, 2);
    // Even kernel size and the largest kernel on a short tall image.
    run_setting(4, 5, 2, 1, 2);
    run_setting(6, 7, 7, 1, 1);
    run_setting(5, 4, 6, 0, 1);
    // A wider two-line image with the largest kernel in gray mode.
    run_setting(40, 2, 7, 0, 1);
    // A tall one-pixel-wide image reaches the top height bits cheaply only
    // through the register write; the frame itself stays short.
    write_reg(REG_HEIGHT, 16'hFFFF);
    run_setting(1, 9, 3, 1, 1);

    // Random part: small images with mixed kernels and modes.
    while (items_sent < 650) begin
      int w, h, k;
      w = $urandom_range(1, 9);
      h = $urandom_range(1, 8);
      k = $urandom_range(0, 7);
      run_setting(w, h, k, 1'($urandom_range(0, 1)), $urandom_range(1, 2));
    end
    wait_idle();

    $display("Covered %0d medians over %0d frames from %0d items, with clipped borders,",
             medians_seen, frames_seen, items_sent);
    $display("all kernel sizes, both color modes and drain ticks at every phase.");
    if (mismatches == 0 && expected_medians.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Safety limit far above the slowest correct run.
  initial begin
    #50ms;
    $display("ERROR: timeout");
    $display("tb_top NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
